/* rtl/rdb_pkg.sv */
package rdb_pkg;

   localparam int FRAME_LENGTH = 64;
   localparam int BINS = FRAME_LENGTH / 2;
   localparam int ADDR_W = $clog2(FRAME_LENGTH);
   localparam int BIN_W = $clog2(BINS);
   localparam int SAMPLE_W = 16;
   localparam int TW_W = 17;
   localparam int PROD_W = SAMPLE_W + TW_W;
   localparam int ACC_W = PROD_W + $clog2(FRAME_LENGTH);
   localparam int OUT_W = 22;
   localparam int BIN_OUT_W = 5;

   localparam logic [63:0] Q62_ONE = 64'd1 << 62;
   localparam logic [63:0] PI_OVER_4_Q62 = 64'h3243F6A8885A308D;
   localparam logic [63:0] PI4_STEP = PI_OVER_4_Q62 / FRAME_LENGTH;
   localparam logic [63:0] PI4_REM = PI_OVER_4_Q62 % FRAME_LENGTH;
   localparam logic [63:0] Q15_HALF = 64'd1 << 46;

   typedef enum logic {
      ST_FILL,
      ST_COMPUTE
   } rdb_state_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic [ADDR_W-1:0] tw_index;
      logic [BIN_W-1:0]  bin;
      logic              first;
      logic              last;
      logic              final_bin;
   } rdb_cmd_type;

   function automatic logic [63:0] mul_q62(input logic [63:0] x, input logic [63:0] y);
      logic [127:0] p;
      p = {64'd0, x} * {64'd0, y};
      return p[125:62];
   endfunction

   // cos and negated sin of 2*pi*m/N in signed q2.15
   function automatic logic [2*TW_W-1:0] twiddle_pair(input int m);
      logic [63:0] a;
      logic [63:0] oct;
      logic [63:0] r;
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] cv;
      logic [63:0] sv;
      logic [TW_W-1:0] c;
      logic [TW_W-1:0] s;
      logic [TW_W-1:0] cq;
      logic [TW_W-1:0] sq;
      a = 64'(8 * (m % FRAME_LENGTH));
      oct = a / FRAME_LENGTH;
      r = a % FRAME_LENGTH;
      if (oct[0]) begin
         r = 64'(FRAME_LENGTH) - r;
      end
      t = PI4_STEP * r + (PI4_REM * r) / FRAME_LENGTH;
      t2 = mul_q62(t, t);
      // taylor series, innermost term first
      cv = Q62_ONE;
      cv = Q62_ONE - mul_q62(t2, cv) / 64'd380;
      cv = Q62_ONE - mul_q62(t2, cv) / 64'd306;
      cv = Q62_ONE - mul_q62(t2, cv) / 64'd240;
      cv = Q62_ONE - mul_q62(t2, cv) / 64'd182;
      cv = Q62_ONE - mul_q62(t2, cv) / 64'd132;
      cv = Q62_ONE - mul_q62(t2, cv) / 64'd90;
      cv = Q62_ONE - mul_q62(t2, cv) / 64'd56;
      cv = Q62_ONE - mul_q62(t2, cv) / 64'd30;
      cv = Q62_ONE - mul_q62(t2, cv) / 64'd12;
      cv = Q62_ONE - mul_q62(t2, cv) / 64'd2;
      sv = Q62_ONE;
      sv = Q62_ONE - mul_q62(t2, sv) / 64'd420;
      sv = Q62_ONE - mul_q62(t2, sv) / 64'd342;
      sv = Q62_ONE - mul_q62(t2, sv) / 64'd272;
      sv = Q62_ONE - mul_q62(t2, sv) / 64'd210;
      sv = Q62_ONE - mul_q62(t2, sv) / 64'd156;
      sv = Q62_ONE - mul_q62(t2, sv) / 64'd110;
      sv = Q62_ONE - mul_q62(t2, sv) / 64'd72;
      sv = Q62_ONE - mul_q62(t2, sv) / 64'd42;
      sv = Q62_ONE - mul_q62(t2, sv) / 64'd20;
      sv = Q62_ONE - mul_q62(t2, sv) / 64'd6;
      sv = mul_q62(t, sv);
      c = TW_W'((cv + Q15_HALF) >> 47);
      s = TW_W'((sv + Q15_HALF) >> 47);
      case (oct[2:0])
         3'd0: begin cq = c;  sq = s;  end
         3'd1: begin cq = s;  sq = c;  end
         3'd2: begin cq = -s; sq = c;  end
         3'd3: begin cq = -c; sq = s;  end
         3'd4: begin cq = -c; sq = -s; end
         3'd5: begin cq = -s; sq = -c; end
         3'd6: begin cq = s;  sq = -c; end
         default: begin cq = c; sq = -s; end
      endcase
      return {cq, TW_W'(-sq)};
   endfunction

   function automatic logic [FRAME_LENGTH-1:0][TW_W-1:0] build_cos_table();
      logic [FRAME_LENGTH-1:0][TW_W-1:0] tab;
      logic [2*TW_W-1:0] pair;
      for (int i = 0; i < FRAME_LENGTH; i++) begin
         pair = twiddle_pair(i);
         tab[i] = pair[2*TW_W-1:TW_W];
      end
      return tab;
   endfunction

   function automatic logic [FRAME_LENGTH-1:0][TW_W-1:0] build_nsin_table();
      logic [FRAME_LENGTH-1:0][TW_W-1:0] tab;
      logic [2*TW_W-1:0] pair;
      for (int i = 0; i < FRAME_LENGTH; i++) begin
         pair = twiddle_pair(i);
         tab[i] = pair[TW_W-1:0];
      end
      return tab;
   endfunction

   localparam logic [FRAME_LENGTH-1:0][TW_W-1:0] COS_TABLE = build_cos_table();
   localparam logic [FRAME_LENGTH-1:0][TW_W-1:0] NSIN_TABLE = build_nsin_table();

endpackage

/* rtl/rdb_ctrl.sv */
module rdb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output rdb_pkg::rdb_cmd_type cmd
);

   localparam logic [rdb_pkg::ADDR_W-1:0] LAST_ADDR = rdb_pkg::ADDR_W'(rdb_pkg::FRAME_LENGTH - 1);
   localparam logic [rdb_pkg::BIN_W-1:0] LAST_BIN = rdb_pkg::BIN_W'(rdb_pkg::BINS - 1);
   localparam logic [rdb_pkg::ADDR_W:0] FRAME_LEN = (rdb_pkg::ADDR_W + 1)'(rdb_pkg::FRAME_LENGTH);

   rdb_pkg::rdb_state_type state_ff, state_in;
   logic [rdb_pkg::ADDR_W-1:0] fill_ff, fill_in;
   logic [rdb_pkg::ADDR_W-1:0] pos_ff, pos_in;
   logic [rdb_pkg::ADDR_W-1:0] tw_ff, tw_in;
   logic [rdb_pkg::BIN_W-1:0]  bin_ff, bin_in;
   logic [rdb_pkg::ADDR_W:0]   tw_sum;
   logic                       accept;
   logic                       pos_last;
   logic                       bin_last;

   assign accept   = (state_ff == rdb_pkg::ST_FILL) && start;
   assign pos_last = (pos_ff == LAST_ADDR);
   assign bin_last = (bin_ff == LAST_BIN);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rdb_pkg::ST_FILL: begin
            if (accept && (fill_ff == LAST_ADDR)) begin
               state_in = rdb_pkg::ST_COMPUTE;
            end
         end
         rdb_pkg::ST_COMPUTE: begin
            if (pos_last && bin_last) begin
               state_in = rdb_pkg::ST_FILL;
            end
         end
         default: state_in = rdb_pkg::ST_FILL;
      endcase
   end

   // twiddle index follows (k*i) mod N by repeated addition of k
   always_comb begin
      fill_in = fill_ff;
      pos_in  = pos_ff;
      tw_in   = tw_ff;
      bin_in  = bin_ff;
      tw_sum  = {1'b0, tw_ff} + (rdb_pkg::ADDR_W + 1)'(bin_ff);
      if (accept) begin
         fill_in = (fill_ff == LAST_ADDR) ? '0 : fill_ff + 1'b1;
      end
      if (state_ff == rdb_pkg::ST_COMPUTE) begin
         if (pos_last) begin
            pos_in = '0;
            tw_in  = '0;
            bin_in = bin_last ? '0 : bin_ff + 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
            tw_in  = (tw_sum >= FRAME_LEN) ? rdb_pkg::ADDR_W'(tw_sum - FRAME_LEN)
                                           : rdb_pkg::ADDR_W'(tw_sum);
         end
      end
   end

   always_comb begin
      busy          = (state_ff == rdb_pkg::ST_COMPUTE);
      cmd.wr_en     = accept;
      cmd.wr_addr   = fill_ff;
      cmd.rd_en     = (state_ff == rdb_pkg::ST_COMPUTE);
      cmd.rd_addr   = pos_ff;
      cmd.tw_index  = tw_ff;
      cmd.bin       = bin_ff;
      cmd.first     = (pos_ff == '0);
      cmd.last      = pos_last;
      cmd.final_bin = bin_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rdb_pkg::ST_FILL;
         fill_ff  <= '0;
         pos_ff   <= '0;
         tw_ff    <= '0;
         bin_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         pos_ff   <= pos_in;
         tw_ff    <= tw_in;
         bin_ff   <= bin_in;
      end
   end

endmodule

/* rtl/rdb_datapath.sv */
module rdb_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rdb_pkg::rdb_cmd_type                   cmd,
   input  logic signed [rdb_pkg::SAMPLE_W-1:0]    req_sample,
   output logic                                   rsp_strobe,
   output logic [rdb_pkg::BIN_OUT_W-1:0]          rsp_bin_index,
   output logic signed [rdb_pkg::OUT_W-1:0]       rsp_real_part,
   output logic signed [rdb_pkg::OUT_W-1:0]       rsp_imag_part,
   output logic                                   rsp_last_bin
);

   localparam int SH_W = rdb_pkg::ACC_W - 14;
   localparam logic signed [SH_W-1:0] SAT_HI = SH_W'(2097151);
   localparam logic signed [SH_W-1:0] SAT_LO = -SH_W'(2097152);
   localparam logic signed [rdb_pkg::ACC_W:0] ROUND_HALF = (rdb_pkg::ACC_W + 1)'(16384);

   typedef struct packed {
      logic                      first;
      logic                      last;
      logic                      final_bin;
      logic [rdb_pkg::BIN_W-1:0] bin;
   } tag_type;

   function automatic logic signed [rdb_pkg::OUT_W-1:0] finish_sum(
      input logic signed [rdb_pkg::ACC_W-1:0] acc
   );
      logic signed [rdb_pkg::ACC_W:0] rnd;
      logic signed [SH_W-1:0]         sh;
      rnd = (rdb_pkg::ACC_W + 1)'(acc) + ROUND_HALF;
      sh  = rnd[rdb_pkg::ACC_W:15];
      if (sh > SAT_HI) begin
         return rdb_pkg::OUT_W'(SAT_HI);
      end else if (sh < SAT_LO) begin
         return rdb_pkg::OUT_W'(SAT_LO);
      end
      return rdb_pkg::OUT_W'(sh);
   endfunction

   logic signed [rdb_pkg::SAMPLE_W-1:0] frame_mem [rdb_pkg::FRAME_LENGTH];

   logic signed [rdb_pkg::SAMPLE_W-1:0] sample_ff;
   logic signed [rdb_pkg::TW_W-1:0]     cos_ff;
   logic signed [rdb_pkg::TW_W-1:0]     nsin_ff;
   logic signed [rdb_pkg::PROD_W-1:0]   prod_re_ff;
   logic signed [rdb_pkg::PROD_W-1:0]   prod_im_ff;
   logic signed [rdb_pkg::ACC_W-1:0]    acc_re_ff, acc_re_in;
   logic signed [rdb_pkg::ACC_W-1:0]    acc_im_ff, acc_im_in;
   logic                                v1_ff, v2_ff, v3_ff;
   tag_type                             tag1_ff, tag2_ff, tag3_ff;
   logic                                strobe_ff;
   logic [rdb_pkg::BIN_OUT_W-1:0]       bin_out_ff;
   logic signed [rdb_pkg::OUT_W-1:0]    real_ff;
   logic signed [rdb_pkg::OUT_W-1:0]    imag_ff;
   logic                                last_out_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         frame_mem[cmd.wr_addr] <= req_sample;
      end
      if (cmd.rd_en) begin
         sample_ff <= frame_mem[cmd.rd_addr];
      end
   end

   always_comb begin
      acc_re_in = tag2_ff.first ? rdb_pkg::ACC_W'(prod_re_ff)
                                : acc_re_ff + rdb_pkg::ACC_W'(prod_re_ff);
      acc_im_in = tag2_ff.first ? rdb_pkg::ACC_W'(prod_im_ff)
                                : acc_im_ff + rdb_pkg::ACC_W'(prod_im_ff);
   end

   always_ff @(posedge clock) begin
      cos_ff     <= signed'(rdb_pkg::COS_TABLE[cmd.tw_index]);
      nsin_ff    <= signed'(rdb_pkg::NSIN_TABLE[cmd.tw_index]);
      tag1_ff    <= '{first: cmd.first, last: cmd.last, final_bin: cmd.final_bin,
                      bin: cmd.bin};
      prod_re_ff <= rdb_pkg::PROD_W'(sample_ff) * rdb_pkg::PROD_W'(cos_ff);
      prod_im_ff <= rdb_pkg::PROD_W'(sample_ff) * rdb_pkg::PROD_W'(nsin_ff);
      tag2_ff    <= tag1_ff;
      if (v2_ff) begin
         acc_re_ff <= acc_re_in;
         acc_im_ff <= acc_im_in;
      end
      tag3_ff    <= tag2_ff;
      if (v3_ff && tag3_ff.last) begin
         bin_out_ff  <= rdb_pkg::BIN_OUT_W'(tag3_ff.bin);
         real_ff     <= finish_sum(acc_re_ff);
         imag_ff     <= finish_sum(acc_im_ff);
         last_out_ff <= tag3_ff.final_bin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         v1_ff     <= cmd.rd_en;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         strobe_ff <= v3_ff && tag3_ff.last;
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_bin_index = bin_out_ff;
   assign rsp_real_part = real_ff;
   assign rsp_imag_part = imag_ff;
   assign rsp_last_bin  = last_out_ff;

endmodule

/* rtl/real_dft_block.sv */
// bins leave in order of k, after the word that completes the frame
// each bin takes one pass through the single real and imaginary mac pair
// busy holds while the bins of a frame are computed
// the receiver cannot stall; each result word is valid for one cycle on rsp_strobe
// synchronous reset clears the fill count, the sequencer and the pipeline valids
module real_dft_block (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [rdb_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_strobe,
   output logic [rdb_pkg::BIN_OUT_W-1:0]       rsp_bin_index,
   output logic signed [rdb_pkg::OUT_W-1:0]    rsp_real_part,
   output logic signed [rdb_pkg::OUT_W-1:0]    rsp_imag_part,
   output logic                                rsp_last_bin
);

   rdb_pkg::rdb_cmd_type cmd;

   rdb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   rdb_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_sample    (req_sample),
      .rsp_strobe    (rsp_strobe),
      .rsp_bin_index (rsp_bin_index),
      .rsp_real_part (rsp_real_part),
      .rsp_imag_part (rsp_imag_part),
      .rsp_last_bin  (rsp_last_bin)
   );

`ifndef NO_ASSERTIONS
   a_strobe_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result words closer than one bin apart");

   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a sample word");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_bin) |-> !busy)
      else $error("last bin word while still computing");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_bin) |-> (rsp_bin_index == rdb_pkg::BIN_OUT_W'(rdb_pkg::BINS - 1)))
      else $error("last bin flag on wrong bin");
`endif

endmodule

/* tb/tb_top.sv */
module tb_top;

   localparam int CLOCK_PERIOD = 12;
   localparam int DIRECTED_WORDS = 24;
   localparam int TOTAL_WORDS = 160;
   localparam int TIMEOUT_CYCLES = 200000;
   localparam real PI = 3.14159265358979323846;

   localparam logic signed [rdb_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [rdb_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef enum int {
      FRAME_MIXED,
      FRAME_CONSTANT,
      FRAME_ALTERNATE,
      FRAME_IMPULSE
   } frame_mode_type;

   typedef struct packed {
      logic [rdb_pkg::BIN_OUT_W-1:0]    bin_index;
      logic signed [rdb_pkg::OUT_W-1:0] real_part;
      logic signed [rdb_pkg::OUT_W-1:0] imag_part;
      logic                             last_bin;
   } bin_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic signed [rdb_pkg::SAMPLE_W-1:0] req_sample = '0;
   logic busy;
   logic rsp_strobe;
   logic [rdb_pkg::BIN_OUT_W-1:0] rsp_bin_index;
   logic signed [rdb_pkg::OUT_W-1:0] rsp_real_part;
   logic signed [rdb_pkg::OUT_W-1:0] rsp_imag_part;
   logic rsp_last_bin;

   logic signed [rdb_pkg::SAMPLE_W-1:0] sample_queue[$];
   bin_word_type bin_queue[$];
   logic signed [rdb_pkg::SAMPLE_W-1:0] frame_words[rdb_pkg::FRAME_LENGTH];
   int cos_q15[rdb_pkg::FRAME_LENGTH];
   int sin_q15[rdb_pkg::FRAME_LENGTH];
   int fill_count = 0;
   int fail_count = 0;
   int gap_left = 0;
   int burst_left = 0;
   logic word_taken = 1'b0;

   real_dft_block dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_sample(req_sample),
      .rsp_strobe(rsp_strobe),
      .rsp_bin_index(rsp_bin_index),
      .rsp_real_part(rsp_real_part),
      .rsp_imag_part(rsp_imag_part),
      .rsp_last_bin(rsp_last_bin)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function automatic int next_gap();
      if (burst_left > 0) begin
         burst_left = burst_left - 1;
         return 0;
      end
      if ($urandom_range(0, 7) == 0) begin
         burst_left = $urandom_range(10, 30);
         return 0;
      end
      return $urandom_range(0, 8);
   endfunction

   function automatic logic signed [rdb_pkg::OUT_W-1:0] round_sum(input longint acc);
      longint v;
      v = (acc + 64'sd16384) >>> 15;
      if (v > 64'sd2097151) begin
         v = 64'sd2097151;
      end
      if (v < -64'sd2097152) begin
         v = -64'sd2097152;
      end
      return rdb_pkg::OUT_W'(v);
   endfunction

   task automatic close_frame();
      longint re_acc;
      longint im_acc;
      int m;
      bin_word_type w;
      for (int k = 0; k < rdb_pkg::BINS; k++) begin
         re_acc = 0;
         im_acc = 0;
         for (int p = 0; p < rdb_pkg::FRAME_LENGTH; p++) begin
            m = (k * p) % rdb_pkg::FRAME_LENGTH;
            re_acc += longint'(frame_words[p]) * longint'(cos_q15[m]);
            im_acc -= longint'(frame_words[p]) * longint'(sin_q15[m]);
         end
         w.bin_index = rdb_pkg::BIN_OUT_W'(k);
         w.real_part = round_sum(re_acc);
         w.imag_part = round_sum(im_acc);
         w.last_bin = (k == rdb_pkg::BINS - 1);
         bin_queue.push_back(w);
      end
   endtask

   task automatic absorb_sample(input logic signed [rdb_pkg::SAMPLE_W-1:0] s);
      frame_words[fill_count] = s;
      fill_count = fill_count + 1;
      if (fill_count == rdb_pkg::FRAME_LENGTH) begin
         fill_count = 0;
         close_frame();
      end
   endtask

   task automatic check_word();
      bin_word_type want;
      if (bin_queue.size() == 0) begin
         if (fail_count < 10) begin
            $display("unexpected word: bin %0d real %0d imag %0d last %0b",
                     rsp_bin_index, rsp_real_part, rsp_imag_part, rsp_last_bin);
         end
         fail_count = fail_count + 1;
      end else begin
         want = bin_queue.pop_front();
         if (rsp_bin_index !== want.bin_index || rsp_real_part !== want.real_part ||
             rsp_imag_part !== want.imag_part || rsp_last_bin !== want.last_bin) begin
            if (fail_count < 10) begin
               $display("mismatch: expected bin %0d real %0d imag %0d last %0b",
                        want.bin_index, want.real_part, want.imag_part, want.last_bin);
               $display("          actual   bin %0d real %0d imag %0d last %0b",
                        rsp_bin_index, rsp_real_part, rsp_imag_part, rsp_last_bin);
            end
            fail_count = fail_count + 1;
         end
      end
   endtask

   // input driver
   always @(negedge clock) begin
      if (!reset) begin
         if (start && !word_taken) begin
         end else if (gap_left != 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (sample_queue.size() != 0) begin
            start <= 1'b1;
            req_sample <= sample_queue.pop_front();
            gap_left <= next_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // accepted words feed the predictor, result words are checked
   always @(posedge clock) begin
      word_taken <= !reset && start && !busy;
      if (!reset) begin
         if (start && !busy) begin
            absorb_sample(req_sample);
         end
         if (rsp_strobe) begin
            check_word();
         end
      end
   end

   initial begin
      logic signed [rdb_pkg::SAMPLE_W-1:0] directed[DIRECTED_WORDS];
      logic signed [rdb_pkg::SAMPLE_W-1:0] value;
      logic signed [rdb_pkg::SAMPLE_W-1:0] const_value;
      frame_mode_type mode;
      int impulse_pos;

      for (int m = 0; m < rdb_pkg::FRAME_LENGTH; m++) begin
         cos_q15[m] = $rtoi($floor($cos(2.0 * PI * m / rdb_pkg::FRAME_LENGTH) * 32768.0
                                   + 0.5));
         sin_q15[m] = $rtoi($floor($sin(2.0 * PI * m / rdb_pkg::FRAME_LENGTH) * 32768.0
                                   + 0.5));
      end

      directed = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001, 16'shFFFF, 16'sh5555,
                   16'shAAAA, 16'sh4000, 16'shC000, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
                   16'sh8000, 16'sh00FF, 16'shFF00, 16'sh7FFE, 16'sh8001, 16'sh0002,
                   16'shFFFE, 16'sh0F0F, 16'shF0F0, 16'sh3039, 16'shCFC7, 16'sh7FFF};
      for (int i = 0; i < DIRECTED_WORDS; i++) begin
         sample_queue.push_back(directed[i]);
      end

      mode = FRAME_MIXED;
      const_value = '0;
      impulse_pos = 0;
      for (int i = DIRECTED_WORDS; i < TOTAL_WORDS; i++) begin
         if (i == DIRECTED_WORDS || i % rdb_pkg::FRAME_LENGTH == 0) begin
            mode = frame_mode_type'($urandom_range(0, 3));
            case ($urandom_range(0, 2))
               0: const_value = SAMPLE_MAX;
               1: const_value = SAMPLE_MIN;
               default: const_value = rdb_pkg::SAMPLE_W'($urandom);
            endcase
            impulse_pos = $urandom_range(i % rdb_pkg::FRAME_LENGTH,
                                         rdb_pkg::FRAME_LENGTH - 1);
         end
         case (mode)
            FRAME_CONSTANT: value = const_value;
            FRAME_ALTERNATE: value = (i % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN;
            FRAME_IMPULSE: value = (i % rdb_pkg::FRAME_LENGTH == impulse_pos) ? const_value
                                                                              : '0;
            default: begin
               case ($urandom_range(0, 9))
                  6: value = SAMPLE_MIN;
                  7: value = SAMPLE_MAX;
                  8: value = rdb_pkg::SAMPLE_W'($signed($urandom_range(0, 8)) - 4);
                  9: value = rdb_pkg::SAMPLE_W'(1 << $urandom_range(0, 15));
                  default: value = rdb_pkg::SAMPLE_W'($urandom);
               endcase
            end
         endcase
         sample_queue.push_back(value);
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (sample_queue.size() != 0 || start || bin_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (4 * rdb_pkg::FRAME_LENGTH) @(posedge clock);
      if (bin_queue.size() != 0) begin
         fail_count = fail_count + 1;
      end
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #(CLOCK_PERIOD * TIMEOUT_CYCLES);
      $display("FAIL");
      $finish;
   end

endmodule
